FILE: sv/crt_pkg.sv
// Package: shared types, constants and name normalization for the registry table.
`timescale 1ns / 1ps
package crt_pkg;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int NAME_CHARS_DEF  = 8;

    localparam logic [2:0] OP_REGISTER   = 3'd0;
    localparam logic [2:0] OP_SEARCH     = 3'd1;
    localparam logic [2:0] OP_DEREGISTER = 3'd2;
    localparam logic [2:0] OP_LIST       = 3'd3;
    localparam logic [2:0] OP_QUIT       = 3'd4;

    localparam logic [3:0] ST_REGISTERED = 4'd0;
    localparam logic [3:0] ST_DUPLICATE  = 4'd1;
    localparam logic [3:0] ST_FULL       = 4'd2;
    localparam logic [3:0] ST_FOUND      = 4'd3;
    localparam logic [3:0] ST_NOT_FOUND  = 4'd4;
    localparam logic [3:0] ST_REMOVED    = 4'd5;
    localparam logic [3:0] ST_NONE_REM   = 4'd6;
    localparam logic [3:0] ST_COUNT      = 4'd7;
    localparam logic [3:0] ST_ENTRY      = 4'd8;
    localparam logic [3:0] ST_EMPTY      = 4'd9;
    localparam logic [3:0] ST_BUSY       = 4'd10;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] peer_key;
        logic [63:0] content_key;
        logic [31:0] ip_address;
        logic [15:0] port_number;
    } t_req;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] out_peer;
        logic [63:0] out_content;
        logic [31:0] out_ip;
        logic [15:0] out_port;
        logic [5:0]  entry_count;
        logic        final_item;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture request, reset scan pointers
        logic rd;         // issue read at scan pointer
        logic advance;    // consume read data (compare/compact), step pointers
        logic wr_append;  // write request at fill position
        logic commit_fill;// fill = write pointer
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic       scan_done;  // scan pointer reached fill
        logic       hit;        // registered data matches the pair
        logic       full;
        logic       empty;
        logic       removed;    // write pointer below fill
    } t_sts;

    // Keep low nchars bytes up to the first zero byte.
    function automatic logic [63:0] name_form(logic [63:0] key, int nchars);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i >= nchars || key[8*i +: 8] == 8'd0) stop = 1'b1;
            if (!stop) r[8*i +: 8] = key[8*i +: 8];
        end
        return r;
    endfunction
endpackage

FILE: sv/crt_datapath.sv
// Datapath: table memory, scan and compaction pointers, fill count.
`timescale 1ns / 1ps
module crt_datapath #(
    parameter int TABLE_DEPTH = crt_pkg::TABLE_DEPTH_DEF,
    parameter int NAME_CHARS  = crt_pkg::NAME_CHARS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  crt_pkg::t_req i_req,
    input  crt_pkg::t_cmd i_cmd,
    output crt_pkg::t_sts o_sts,
    output logic [5:0]    o_fill,
    output logic [5:0]    o_rd_idx,
    output logic [63:0]   o_peer,
    output logic [63:0]   o_content,
    output logic [47:0]   o_addr
);
    import crt_pkg::*;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [175:0] r_mem [TABLE_DEPTH];
    logic [175:0] r_rdata;
    logic [63:0]  r_peer, r_content;
    logic [47:0]  r_addr_in;
    logic [5:0]   r_fill, r_rp, r_wp, r_ridx;

    assign o_peer    = r_rdata[175:112];
    assign o_content = r_rdata[111:48];
    assign o_addr    = r_rdata[47:0];
    assign o_fill    = r_fill;
    assign o_rd_idx  = r_ridx;

    assign o_sts.scan_done = (r_rp >= r_fill);
    assign o_sts.hit       = (o_peer == r_peer) && (o_content == r_content);
    assign o_sts.full      = (r_fill >= 6'(TABLE_DEPTH));
    assign o_sts.empty     = (r_fill == 6'd0);
    assign o_sts.removed   = (r_wp < r_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            if (i_cmd.wr_append) r_fill <= r_fill + 6'd1;
            else if (i_cmd.commit_fill) r_fill <= r_wp;
        end
        if (i_cmd.load) begin
            r_peer    <= name_form(i_req.peer_key, NAME_CHARS);
            r_content <= name_form(i_req.content_key, NAME_CHARS);
            r_addr_in <= {i_req.ip_address, i_req.port_number};
            r_rp      <= '0;
            r_wp      <= '0;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_rp[AW-1:0]];
            r_ridx  <= r_rp;
            r_rp    <= r_rp + 6'd1;
        end
        // Compaction keeps entries of other peers, writing them down in order.
        if (i_cmd.advance && o_peer != r_peer) begin
            r_mem[r_wp[AW-1:0]] <= r_rdata;
            r_wp <= r_wp + 6'd1;
        end
        if (i_cmd.wr_append)
            r_mem[r_fill[AW-1:0]] <= {r_peer, r_content, r_addr_in};
    end
endmodule

FILE: sv/crt_ctrl.sv
// Controller: sequences one operation over the table and issues results.
`timescale 1ns / 1ps
module crt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_op,
    input  crt_pkg::t_sts i_sts,
    input  logic [5:0]    i_fill,
    input  logic [5:0]    i_rd_idx,
    input  logic [63:0]   i_peer,
    input  logic [63:0]   i_content,
    input  logic [47:0]   i_addr,
    output crt_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_valid,
    output crt_pkg::t_rsp o_rsp
);
    import crt_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_CHECK, S_LIST} t_state;

    t_state     r_state, n_state;
    logic [2:0] r_op, n_op;
    logic       r_valid, n_valid;
    t_rsp       r_rsp, n_rsp;

    function automatic t_rsp rsp(logic [3:0] st);
        t_rsp r;
        r = '0;
        r.status = st;
        r.final_item = 1'b1;
        return r;
    endfunction

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_start;
        case (r_state)
            S_ISSUE: o_cmd.rd = !i_sts.scan_done;
            S_WAIT:  o_cmd.advance = (r_op == OP_DEREGISTER);
            S_CHECK: o_cmd.wr_append = (r_op == OP_REGISTER) && !i_sts.full;
            default: ;
        endcase
        if (r_state == S_ISSUE && i_sts.scan_done && r_op == OP_DEREGISTER)
            o_cmd.commit_fill = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_valid = 1'b0;
        n_rsp   = r_rsp;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op = i_op;
                    case (i_op)
                        OP_REGISTER, OP_SEARCH, OP_DEREGISTER:
                            n_state = S_ISSUE;
                        OP_LIST: begin
                            n_state = S_ISSUE;
                            n_valid = 1'b1;
                            n_rsp   = rsp(ST_COUNT);
                            n_rsp.entry_count = i_fill;
                            n_rsp.final_item  = i_sts.empty;
                        end
                        OP_QUIT: begin
                            n_valid = 1'b1;
                            n_rsp   = rsp(i_sts.empty ? ST_EMPTY : ST_BUSY);
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                if (i_sts.scan_done) begin
                    case (r_op)
                        OP_REGISTER: n_state = S_CHECK;
                        OP_SEARCH: begin
                            n_valid = 1'b1;
                            n_rsp   = rsp(ST_NOT_FOUND);
                            n_state = S_IDLE;
                        end
                        OP_DEREGISTER: begin
                            n_valid = 1'b1;
                            n_rsp   = rsp(i_sts.removed ? ST_REMOVED : ST_NONE_REM);
                            n_state = S_IDLE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end else begin
                    n_state = (r_op == OP_LIST) ? S_LIST : S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_ISSUE;
                if (i_sts.full && r_op == OP_REGISTER) begin
                    n_state = S_CHECK;
                end else if (i_sts.hit && r_op == OP_REGISTER) begin
                    n_valid = 1'b1;
                    n_rsp   = rsp(ST_DUPLICATE);
                    n_state = S_IDLE;
                end else if (i_sts.hit && r_op == OP_SEARCH) begin
                    n_valid = 1'b1;
                    n_rsp   = rsp(ST_FOUND);
                    n_rsp.out_peer    = i_peer;
                    n_rsp.out_content = i_content;
                    n_rsp.out_ip      = i_addr[47:16];
                    n_rsp.out_port    = i_addr[15:0];
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                n_valid = 1'b1;
                n_rsp   = rsp(i_sts.full ? ST_FULL : ST_REGISTERED);
                n_state = S_IDLE;
            end
            S_LIST: begin
                n_valid = 1'b1;
                n_rsp   = rsp(ST_ENTRY);
                n_rsp.out_peer    = i_peer;
                n_rsp.out_content = i_content;
                n_rsp.out_ip      = i_addr[47:16];
                n_rsp.out_port    = i_addr[15:0];
                n_rsp.final_item  = (i_rd_idx + 6'd1 == i_fill);
                n_state = S_ISSUE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= '0;
            r_valid <= 1'b0;
            r_rsp   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_valid <= n_valid;
            r_rsp   <= n_rsp;
        end
    end
endmodule

FILE: sv/content_registry_table_top.sv
// Top level: ordered registry table of (peer, content) pairs with compaction.
// Quit is answered straight from idle; register/search/deregister scan the table;
// list gives the count next cycle, then each table entry in order.
// Throughput: one item at a time; busy stays high until the final result is sent.
// The table scan, reading each entry in turn, sets the operation length.
// Reset (synchronous, active low) empties the table; the receiver cannot stall.
`timescale 1ns / 1ps
module content_registry_table_top #(
    parameter int TABLE_DEPTH = crt_pkg::TABLE_DEPTH_DEF,
    parameter int NAME_CHARS  = crt_pkg::NAME_CHARS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  crt_pkg::t_req i_req,
    output logic          o_strobe,
    output crt_pkg::t_rsp o_rsp
);
    import crt_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [5:0]  w_fill, w_ridx;
    logic [63:0] w_peer, w_content;
    logic [47:0] w_addr;

    // Datapath holds the table and walks it on controller command.
    crt_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .NAME_CHARS(NAME_CHARS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_fill(w_fill), .o_rd_idx(w_ridx),
        .o_peer(w_peer), .o_content(w_content), .o_addr(w_addr)
    );

    // Controller sequences each item and drives the result register.
    crt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_op(i_req.operation),
        .i_sts(w_sts), .i_fill(w_fill), .i_rd_idx(w_ridx),
        .i_peer(w_peer), .i_content(w_content), .i_addr(w_addr),
        .o_cmd(w_cmd), .o_busy(busy), .o_valid(o_strobe), .o_rsp(o_rsp)
    );
endmodule

FILE: test/tb_content_registry_table_top.sv
// Testbench for the registry table: queued driver, strobe monitor, in-bench table predictor.
`timescale 1ns / 1ps
module tb_content_registry_table_top;
    import crt_pkg::*;

    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_strobe;
    t_rsp  o_rsp;

    content_registry_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_rsp   (o_rsp)
    );

    // 12 ns period: 6 ns high, 6 ns low.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Predictor's own copy of the table.
    logic [63:0] tbl_peer [DEPTH];
    logic [63:0] tbl_content [DEPTH];
    logic [31:0] tbl_ip [DEPTH];
    logic [15:0] tbl_port [DEPTH];
    int          tbl_fill;

    t_req pending_items[$];
    t_rsp expected_rsps[$];
    int   sender_idle_pct;
    int   error_count;
    int   quiet_cycles;

    // Truncate a key at its first zero byte.
    function automatic logic [63:0] trim_name(logic [63:0] key);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (key[8*i +: 8] == 8'd0) break;
            r[8*i +: 8] = key[8*i +: 8];
        end
        return r;
    endfunction

    function automatic t_rsp make_rsp(logic [3:0] st, logic fin);
        t_rsp r;
        r = '0;
        r.status     = st;
        r.final_item = fin;
        return r;
    endfunction

    // Apply one accepted item to the table and queue the results it causes.
    task automatic predict_table(t_req q);
        logic [63:0] pk, ck;
        int          hit, w;
        t_rsp        r;
        pk  = trim_name(q.peer_key);
        ck  = trim_name(q.content_key);
        hit = -1;
        for (int i = 0; i < tbl_fill; i++)
            if (hit < 0 && tbl_peer[i] == pk && tbl_content[i] == ck) hit = i;
        case (q.operation)
            OP_REGISTER: begin
                if (tbl_fill >= DEPTH) begin
                    expected_rsps.push_back(make_rsp(ST_FULL, 1'b1));
                end else if (hit >= 0) begin
                    expected_rsps.push_back(make_rsp(ST_DUPLICATE, 1'b1));
                end else begin
                    tbl_peer[tbl_fill]    = pk;
                    tbl_content[tbl_fill] = ck;
                    tbl_ip[tbl_fill]      = q.ip_address;
                    tbl_port[tbl_fill]    = q.port_number;
                    tbl_fill++;
                    expected_rsps.push_back(make_rsp(ST_REGISTERED, 1'b1));
                end
            end
            OP_SEARCH: begin
                if (hit < 0) begin
                    expected_rsps.push_back(make_rsp(ST_NOT_FOUND, 1'b1));
                end else begin
                    r = make_rsp(ST_FOUND, 1'b1);
                    r.out_peer    = tbl_peer[hit];
                    r.out_content = tbl_content[hit];
                    r.out_ip      = tbl_ip[hit];
                    r.out_port    = tbl_port[hit];
                    expected_rsps.push_back(r);
                end
            end
            OP_DEREGISTER: begin
                w = 0;
                for (int i = 0; i < tbl_fill; i++) begin
                    if (tbl_peer[i] != pk) begin
                        tbl_peer[w]    = tbl_peer[i];
                        tbl_content[w] = tbl_content[i];
                        tbl_ip[w]      = tbl_ip[i];
                        tbl_port[w]    = tbl_port[i];
                        w++;
                    end
                end
                if (w < tbl_fill) begin
                    tbl_fill = w;
                    expected_rsps.push_back(make_rsp(ST_REMOVED, 1'b1));
                end else begin
                    expected_rsps.push_back(make_rsp(ST_NONE_REM, 1'b1));
                end
            end
            OP_LIST: begin
                r = make_rsp(ST_COUNT, tbl_fill == 0);
                r.entry_count = 6'(tbl_fill);
                expected_rsps.push_back(r);
                for (int i = 0; i < tbl_fill; i++) begin
                    r = make_rsp(ST_ENTRY, i + 1 == tbl_fill);
                    r.out_peer    = tbl_peer[i];
                    r.out_content = tbl_content[i];
                    r.out_ip      = tbl_ip[i];
                    r.out_port    = tbl_port[i];
                    expected_rsps.push_back(r);
                end
            end
            OP_QUIT: begin
                expected_rsps.push_back(make_rsp(tbl_fill == 0 ? ST_EMPTY : ST_BUSY, 1'b1));
            end
            default: ;  // unused codes give no result
        endcase
    endtask

    // Driver: hold start and the item until accepted, then advance the queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            // The item on the port (if start was high) is taken at this edge.
            if (start) predict_table(i_req);
            if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                start <= 1'b1;
                i_req <= pending_items.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare every strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_strobe) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_rsp);
                error_count++;
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (o_rsp.status !== exp_rsp.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_rsp.status, o_rsp.status);
                    error_count++;
                end
                if (o_rsp.out_peer !== exp_rsp.out_peer) begin
                    $display("%0t: out_peer expected %h actual %h",
                             $time, exp_rsp.out_peer, o_rsp.out_peer);
                    error_count++;
                end
                if (o_rsp.out_content !== exp_rsp.out_content) begin
                    $display("%0t: out_content expected %h actual %h",
                             $time, exp_rsp.out_content, o_rsp.out_content);
                    error_count++;
                end
                if (o_rsp.out_ip !== exp_rsp.out_ip) begin
                    $display("%0t: out_ip expected %h actual %h",
                             $time, exp_rsp.out_ip, o_rsp.out_ip);
                    error_count++;
                end
                if (o_rsp.out_port !== exp_rsp.out_port) begin
                    $display("%0t: out_port expected %h actual %h",
                             $time, exp_rsp.out_port, o_rsp.out_port);
                    error_count++;
                end
                if (o_rsp.entry_count !== exp_rsp.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, exp_rsp.entry_count, o_rsp.entry_count);
                    error_count++;
                end
                if (o_rsp.final_item !== exp_rsp.final_item) begin
                    $display("%0t: final_item expected %b actual %b",
                             $time, exp_rsp.final_item, o_rsp.final_item);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no item and no result accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("content_registry_table_top test failed");
                $finish;
            end
        end
    end

    // Small pools so that random keys collide often.
    logic [63:0] peer_pool [8];
    logic [63:0] content_pool [8];

    function automatic t_req build_item(logic [2:0] op, logic [63:0] pk, logic [63:0] ck,
                                        logic [31:0] ip, logic [15:0] port);
        t_req q;
        q.operation   = op;
        q.peer_key    = pk;
        q.content_key = ck;
        q.ip_address  = ip;
        q.port_number = port;
        return q;
    endfunction

    // Pool key, sometimes with garbage above an embedded zero byte.
    function automatic logic [63:0] pick_key(bit is_peer);
        logic [63:0] k;
        int          cut;
        k = is_peer ? peer_pool[$urandom_range(7)] : content_pool[$urandom_range(7)];
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(7);
            k[8*cut +: 8] = 8'd0;
            for (int i = cut + 1; i < 8; i++) k[8*i +: 8] = 8'($urandom);
        end
        return k;
    endfunction

    task automatic queue_random(int count);
        logic [2:0] op;
        int         sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 40)      op = OP_REGISTER;
            else if (sel < 65) op = OP_SEARCH;
            else if (sel < 77) op = OP_DEREGISTER;
            else if (sel < 87) op = OP_LIST;
            else if (sel < 95) op = OP_QUIT;
            else               op = 3'($urandom_range(5, 7));
            pending_items.push_back(build_item(op, pick_key(1), pick_key(0),
                                               $urandom, 16'($urandom)));
        end
    endtask

    task automatic drain_phase();
        while (pending_items.size() > 0 || start || busy || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_req           = '0;
        error_count     = 0;
        quiet_cycles    = 0;
        tbl_fill        = 0;
        sender_idle_pct = 14;
        for (int i = 0; i < 8; i++) begin
            peer_pool[i]    = {$urandom, $urandom};
            content_pool[i] = {$urandom, $urandom};
        end
        peer_pool[0]    = 64'hFFFF_FFFF_FFFF_FFFF;
        peer_pool[1]    = 64'h0;
        content_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        content_pool[1] = 64'h0;
        peer_pool[2]    = 64'h0000_0000_0000_0041;

        // Directed: empty table checks, extremes, duplicates, truncated names, unused code.
        pending_items.push_back(build_item(OP_QUIT, 64'h0, 64'h0, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_LIST, 64'h0, 64'h0, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_SEARCH, 64'h1, 64'h1, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_DEREGISTER, 64'h1, 64'h0, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_REGISTER, '1, '1, '1, '1));
        pending_items.push_back(build_item(OP_REGISTER, '0, '0, '0, '0));
        pending_items.push_back(build_item(OP_REGISTER, '1, '1, 32'h1234, 16'h5));
        pending_items.push_back(build_item(OP_REGISTER, 64'hFF00_0041, 64'h7700_0042,
                                           32'hC0A8_0001, 16'h1F90));
        pending_items.push_back(build_item(OP_SEARCH, 64'h41, 64'h42, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_SEARCH, '1, '1, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_REGISTER, 64'h41, 64'h43, 32'h5555_AAAA, 16'hA5A5));
        pending_items.push_back(build_item(OP_LIST, 64'h0, 64'h0, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_QUIT, 64'h0, 64'h0, 32'h0, 16'h0));
        pending_items.push_back(build_item(3'd7, '1, '1, '1, '1));
        pending_items.push_back(build_item(OP_UNUSED_LO, 64'h0, 64'h0, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_DEREGISTER, 64'hAB00_0041, 64'h0, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_LIST, 64'h0, 64'h0, 32'h0, 16'h0));
        // Fill to the limit, then hit full.
        for (int i = 0; i < DEPTH + 2; i++)
            pending_items.push_back(build_item(OP_REGISTER, 64'h50, 64'(i + 1),
                                               $urandom, 16'($urandom)));
        pending_items.push_back(build_item(OP_LIST, 64'h0, 64'h0, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_DEREGISTER, 64'h50, 64'h0, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_DEREGISTER, '1, 64'h0, 32'h0, 16'h0));
        pending_items.push_back(build_item(OP_QUIT, 64'h0, 64'h0, 32'h0, 16'h0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_random(70);
        drain_phase();
        sender_idle_pct = 63;
        queue_random(70);
        drain_phase();
        sender_idle_pct = 0;
        queue_random(65);
        drain_phase();

        // Let any late stray result show up.
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("content_registry_table_top test passed");
        end else begin
            $display("content_registry_table_top test failed");
        end
        $finish;
    end
endmodule
